### rtl/hmm_pkg.sv
package hmm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;

   localparam int DATA_W = 32;
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   // exact dot product of up to MAX_DIM Q16.16 products
   localparam int ACC_W  = 2 * DATA_W + IDX_W;
   localparam int FULL_W = ACC_W + DATA_W;
   localparam int SHIFT  = 2 * FRAC_BITS;
   localparam int CSR_AW = 5;

   localparam logic [1:0] OP_LOAD_H  = 2'd0;
   localparam logic [1:0] OP_LOAD_A  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [2:0] REG_SIDE      = 3'd0;
   localparam logic [2:0] REG_TRANSPOSE = 3'd1;
   localparam logic [2:0] REG_ROWS      = 3'd2;
   localparam logic [2:0] REG_COLS      = 3'd3;
   localparam logic [2:0] REG_SCALE     = 3'd4;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] element_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_row;
      logic [2:0]         out_col;
      logic signed [31:0] result_value;
      logic               last;
   } rsp_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             h_zero;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } walk_meta_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] d);
      return (int'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(d);
   endfunction

endpackage

### rtl/hmm_store.sv
module hmm_store
   import hmm_pkg::*;
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

### rtl/hmm_walk.sv
module hmm_walk
   import hmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start_compute,
   input  logic              side,
   input  logic              transpose,
   input  logic [DIM_W-1:0]  m,
   input  logic [DIM_W-1:0]  n,
   output logic              busy,
   output logic [ADDR_W-1:0] h_addr,
   output logic [ADDR_W-1:0] a_addr,
   output walk_meta_type     meta
);

   walk_state_type   state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;

   logic [DIM_W-1:0] inner;
   logic             last_k, last_i, last_j;
   logic [IDX_W-1:0] op_r, op_c, hr, hc, a_r, a_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      inner  = side ? n : m;
      last_k = DIM_W'(k_ff) == inner - DIM_W'(1);
      last_i = DIM_W'(i_ff) == m - DIM_W'(1);
      last_j = DIM_W'(j_ff) == n - DIM_W'(1);

      // op(H) coordinates, then the stored H position
      op_r = side ? k_ff : i_ff;
      op_c = side ? j_ff : k_ff;
      hr   = transpose ? op_c : op_r;
      hc   = transpose ? op_r : op_c;
      a_r  = side ? i_ff : k_ff;
      a_c  = side ? k_ff : j_ff;

      h_addr = addr_of(hr, hc);
      a_addr = addr_of(a_r, a_c);

      meta.valid  = state_ff == WALK_RUN;
      meta.first  = k_ff == '0;
      meta.last_k = last_k;
      // below the subdiagonal
      meta.h_zero = DIM_W'(hr) > DIM_W'(hc) + DIM_W'(1);
      meta.row    = i_ff;
      meta.col    = j_ff;
      meta.last   = last_k && last_i && last_j;

      busy = state_ff == WALK_RUN;

      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      unique case (state_ff)
         WALK_IDLE: begin
            if (start_compute && m != '0 && n != '0) begin
               state_in = WALK_RUN;
            end
         end
         WALK_RUN: begin
            if (last_k) begin
               k_in = '0;
               if (last_i) begin
                  i_in = '0;
                  if (last_j) begin
                     j_in     = '0;
                     state_in = WALK_IDLE;
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
      endcase
   end

endmodule

### rtl/hmm_mac.sv
module hmm_mac
   import hmm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  walk_meta_type            meta,
   input  logic signed [DATA_W-1:0] h_data,
   input  logic signed [DATA_W-1:0] a_data,
   input  logic signed [DATA_W-1:0] scale_factor,
   output logic                     rsp_valid,
   output rsp_type                  rsp_payload
);

   localparam logic signed [FULL_W-1:0] SAT_HI = FULL_W'(32'sh7fff_ffff);
   localparam logic signed [FULL_W-1:0] SAT_LO = FULL_W'(32'sh8000_0000);

   walk_meta_type meta_r_ff, meta_p_ff, meta_a_ff, meta_1_ff, meta_2_ff;
   walk_meta_type meta_a_in;

   logic signed [2*DATA_W-1:0]    prod_in, prod_ff;
   logic signed [ACC_W-1:0]       acc_in, acc_ff;
   logic signed [2*DATA_W:0]      plo_ff, plo2_ff;
   logic signed [ACC_W-DATA_W-1:0] shi_ff;
   logic signed [ACC_W-1:0]       phi_ff;
   logic signed [FULL_W-1:0]      full_sum, quot;
   logic signed [DATA_W-1:0]      sat_value;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_r_ff    <= '0;
         meta_p_ff    <= '0;
         meta_a_ff    <= '0;
         meta_1_ff    <= '0;
         meta_2_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         meta_r_ff    <= meta;
         meta_p_ff    <= meta_r_ff;
         meta_a_ff    <= meta_a_in;
         meta_1_ff    <= meta_a_ff;
         meta_2_ff    <= meta_1_ff;
         rsp_valid_ff <= meta_2_ff.valid;
      end
   end

   always_comb begin
      if (meta_r_ff.h_zero) begin
         prod_in = '0;
      end else begin
         prod_in = h_data * a_data;
      end
      acc_in  = meta_p_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      // only a finished sum moves on to scaling
      meta_a_in       = meta_p_ff;
      meta_a_in.valid = meta_p_ff.valid && meta_p_ff.last_k;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (meta_p_ff.valid) begin
         acc_ff <= acc_in;
      end
      // alpha times the sum, split into a low and a high partial product
      plo_ff  <= $signed({1'b0, acc_ff[DATA_W-1:0]}) * scale_factor;
      shi_ff  <= acc_ff[ACC_W-1:DATA_W];
      phi_ff  <= shi_ff * scale_factor;
      plo2_ff <= plo_ff;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      full_sum = (FULL_W'(phi_ff) <<< DATA_W) + FULL_W'(plo2_ff);
      quot     = full_sum >>> SHIFT;
      if (quot > SAT_HI) begin
         sat_value = 32'sh7fff_ffff;
      end else if (quot < SAT_LO) begin
         sat_value = 32'sh8000_0000;
      end else begin
         sat_value = quot[DATA_W-1:0];
      end
      rsp_in.out_row      = 3'(meta_2_ff.row);
      rsp_in.out_col      = 3'(meta_2_ff.col);
      rsp_in.result_value = sat_value;
      rsp_in.last         = meta_2_ff.last;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/hessenberg_matrix_multiply_unit.sv
// Upper Hessenberg product unit. Load requests (H entry or A entry) are taken one per
// cycle whenever busy is low. A compute request with m and n both nonzero raises busy
// while the walk issues one H/A read pair per cycle from the two entry stores; each
// result sums k products, k being m (side 0) or n (side 1). Results leave in column-major
// order, one per m*n entry, after the store read, product, accumulator, partial-product
// and response registers. A new request may be taken the cycle after busy falls while
// results still drain. rsp_valid marks each result for one cycle and cannot be held off.
// Configuration is to be written over the APB port only while no work is in flight;
// the block itself does not enforce this.
module hessenberg_matrix_multiply_unit
   import hmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic              rsp_valid,
   output rsp_type           rsp_payload
);

   logic               side_ff;
   logic               transpose_ff;
   logic [3:0]         rows_ff;
   logic [3:0]         cols_ff;
   logic signed [31:0] scale_ff;

   logic              csr_write;
   logic [2:0]        csr_index;
   logic              accept, in_range, start_compute;
   logic              load_h_en, load_a_en;
   logic [ADDR_W-1:0] wr_addr, h_addr, a_addr;
   logic signed [DATA_W-1:0] h_data, a_data;
   logic [DIM_W-1:0]  m, n;
   walk_meta_type     meta;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= 1'b0;
         transpose_ff <= 1'b0;
         rows_ff      <= '0;
         cols_ff      <= '0;
         scale_ff     <= 32'sd65536;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SIDE:      side_ff      <= pwdata[0];
            REG_TRANSPOSE: transpose_ff <= pwdata[0];
            REG_ROWS:      rows_ff      <= pwdata[3:0];
            REG_COLS:      cols_ff      <= pwdata[3:0];
            REG_SCALE:     scale_ff     <= $signed(pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SIDE:      prdata = {31'd0, side_ff};
         REG_TRANSPOSE: prdata = {31'd0, transpose_ff};
         REG_ROWS:      prdata = {28'd0, rows_ff};
         REG_COLS:      prdata = {28'd0, cols_ff};
         REG_SCALE:     prdata = scale_ff;
         default:       prdata = '0;
      endcase
   end

   assign accept        = start && !busy;
   assign in_range      = int'(req_payload.row) < MAX_DIM && int'(req_payload.col) < MAX_DIM;
   assign load_h_en     = accept && req_payload.operation == OP_LOAD_H && in_range;
   assign load_a_en     = accept && req_payload.operation == OP_LOAD_A && in_range;
   assign start_compute = accept && req_payload.operation == OP_COMPUTE;
   assign wr_addr       = addr_of(req_payload.row[IDX_W-1:0], req_payload.col[IDX_W-1:0]);
   assign m             = clamp_dim(rows_ff);
   assign n             = clamp_dim(cols_ff);

   hmm_store u_h_store (
      .clock   (clock),
      .wr_en   (load_h_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.element_value),
      .rd_addr (h_addr),
      .rd_data (h_data)
   );

   hmm_store u_a_store (
      .clock   (clock),
      .wr_en   (load_a_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.element_value),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   hmm_walk u_walk (
      .clock         (clock),
      .reset         (reset),
      .start_compute (start_compute),
      .side          (side_ff),
      .transpose     (transpose_ff),
      .m             (m),
      .n             (n),
      .busy          (busy),
      .h_addr        (h_addr),
      .a_addr        (a_addr),
      .meta          (meta)
   );

   hmm_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .meta         (meta),
      .h_data       (h_data),
      .a_data       (a_data),
      .scale_factor (scale_ff),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

### rtl/hmm_checker.sv
module hmm_checker
   import hmm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input req_type           req_payload,
   input logic              psel,
   input logic              pwrite,
   input logic [CSR_AW-1:0] paddr,
   input logic [31:0]       prdata,
   input logic              rsp_valid,
   input rsp_type           rsp_payload
);

   // nothing in flight right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy right after reset");

   // the walk only starts from an accepted compute request
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(req_payload.operation == OP_COMPUTE))
      else $error("busy rose without a compute request");

   // a new run cannot produce a result right after the final one of the previous run
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |=> !rsp_valid)
      else $error("result directly after a last result");

   // addresses past the register list read as zero
   a_unmapped_read: assert property (@(posedge clock) disable iff (reset)
      psel && !pwrite && (paddr[4:2] > REG_SCALE)
      |-> prdata == 32'd0)
      else $error("unmapped register read nonzero");

endmodule

bind hessenberg_matrix_multiply_unit hmm_checker u_checker (.*);

### dv/hessenberg_matrix_multiply_unit_tb.sv
module hessenberg_matrix_multiply_unit_tb;
   import hmm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 270;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT = 5000;
   localparam logic signed [95:0] Q_MAX = 96'sd2147483647;
   localparam logic signed [95:0] Q_MIN = -96'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic rsp_valid;
   rsp_type rsp_payload;

   // shadow of the block: configuration and both entry stores
   logic cfg_side = 1'b0;
   logic cfg_transpose = 1'b0;
   logic [3:0] cfg_rows = 4'd0;
   logic [3:0] cfg_cols = 4'd0;
   logic signed [31:0] cfg_scale = 32'sh00010000;
   logic signed [31:0] h_mem [MAX_DIM][MAX_DIM];
   logic signed [31:0] a_mem [MAX_DIM][MAX_DIM];

   // which entries the request stream has loaded so far
   bit h_loaded [MAX_DIM][MAX_DIM];
   bit a_loaded [MAX_DIM][MAX_DIM];

   req_type request_queue[$];
   rsp_type product_queue[$];
   req_type cur_request;
   rsp_type want;
   int request_count = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int phase;
   int seg_count;

   hessenberg_matrix_multiply_unit uut (.*);

   always #1 clock = ~clock;

   function automatic logic signed [31:0] h_view(int r, int c);
      int hr;
      int hc;
      hr = cfg_transpose ? c : r;
      hc = cfg_transpose ? r : c;
      if (hr > hc + 1) return '0;
      return h_mem[hr][hc];
   endfunction

   task automatic predict_product();
      int m;
      int n;
      int inner;
      logic signed [66:0] acc;
      logic signed [127:0] scaled;
      logic signed [95:0] quo;
      logic signed [31:0] hval;
      logic signed [31:0] aval;
      rsp_type r;
      m = (cfg_rows > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
      n = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
      if (m == 0 || n == 0) return;
      inner = cfg_side ? n : m;
      for (int j = 0; j < n; j++) begin
         for (int i = 0; i < m; i++) begin
            acc = '0;
            for (int k = 0; k < inner; k++) begin
               if (!cfg_side) begin
                  hval = h_view(i, k);
                  aval = a_mem[k][j];
               end else begin
                  aval = a_mem[i][k];
                  hval = h_view(k, j);
               end
               acc = acc + hval * aval;
            end
            scaled = acc * cfg_scale;
            // arithmetic shift floors toward minus infinity
            quo = 96'(scaled >>> SHIFT);
            r.out_row = i[2:0];
            r.out_col = j[2:0];
            if (quo > Q_MAX) r.result_value = 32'sh7fffffff;
            else if (quo < Q_MIN) r.result_value = 32'sh80000000;
            else r.result_value = quo[31:0];
            r.last = (i == m - 1 && j == n - 1);
            product_queue.push_back(r);
         end
      end
   endtask

   task automatic apply_request(req_type rq);
      case (rq.operation)
         OP_LOAD_H: h_mem[rq.row][rq.col] = rq.element_value;
         OP_LOAD_A: a_mem[rq.row][rq.col] = rq.element_value;
         OP_COMPUTE: predict_product();
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return '0;
         3: return $urandom();
         default: return $urandom_range(32'h7ffff) - 32'h40000;
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return '0;
         3: return 32'h00010000;
         4: return 32'hffff0000;
         5: return $urandom();
         default: return $urandom_range(32'h7ffff) - 32'h40000;
      endcase
   endfunction

   function automatic logic [3:0] pick_dim();
      case ($urandom_range(9))
         0: return 4'd0;
         1: return 4'd8;
         2: return 4'($urandom_range(9, 15));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic push_item(logic [1:0] op, int r, int c, logic [31:0] v);
      req_type rq;
      rq.operation = op;
      rq.row = r[2:0];
      rq.col = c[2:0];
      rq.element_value = v;
      request_queue.push_back(rq);
      if (op == OP_LOAD_H) h_loaded[r][c] = 1'b1;
      else if (op == OP_LOAD_A) a_loaded[r][c] = 1'b1;
      if (op != OP_UNUSED) request_count++;
   endtask

   task automatic need_h(int r, int c);
      int hr;
      int hc;
      hr = cfg_transpose ? c : r;
      hc = cfg_transpose ? r : c;
      if (hr <= hc + 1 && !h_loaded[hr][hc]) push_item(OP_LOAD_H, hr, hc, rand_value());
   endtask

   task automatic need_a(int r, int c);
      if (!a_loaded[r][c]) push_item(OP_LOAD_A, r, c, rand_value());
   endtask

   // loads every entry the product will read that was never loaded, then computes
   task automatic push_compute();
      int m;
      int n;
      m = (cfg_rows > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
      n = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
      if (m != 0 && n != 0) begin
         if (!cfg_side) begin
            for (int i = 0; i < m; i++)
               for (int k = 0; k < m; k++) need_h(i, k);
            for (int k = 0; k < m; k++)
               for (int j = 0; j < n; j++) need_a(k, j);
         end else begin
            for (int i = 0; i < m; i++)
               for (int k = 0; k < n; k++) need_a(i, k);
            for (int k = 0; k < n; k++)
               for (int j = 0; j < n; j++) need_h(k, j);
         end
      end
      push_item(OP_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom());
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (request_queue.size() != 0 || start || busy || product_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SIDE: cfg_side = value[0];
         REG_TRANSPOSE: cfg_transpose = value[0];
         REG_ROWS: cfg_rows = value[3:0];
         REG_COLS: cfg_cols = value[3:0];
         REG_SCALE: cfg_scale = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(bit sd, bit tr, logic [3:0] rows, logic [3:0] cols,
                             logic [31:0] scale);
      wait_idle();
      csr_write(REG_SIDE, 32'(sd));
      csr_write(REG_TRANSPOSE, 32'(tr));
      csr_write(REG_ROWS, 32'(rows));
      csr_write(REG_COLS, 32'(cols));
      csr_write(REG_SCALE, scale);
   endtask

   // request driver: start stays high until the block takes the request
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(cur_request);
            accepted_count++;
         end
         if (!start || !busy) begin
            if (request_queue.size() != 0 && $urandom_range(99) >=
                (accepted_count < 90 ? 22 : (accepted_count < 180 ? 63 : 0))) begin
               cur_request = request_queue.pop_front();
               req_payload <= cur_request;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (product_queue.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: row %0d col %0d value %h last %b",
                        rsp_payload.out_row, rsp_payload.out_col,
                        rsp_payload.result_value, rsp_payload.last);
            mismatch_count++;
         end else begin
            want = product_queue.pop_front();
            if (rsp_payload.out_row !== want.out_row || rsp_payload.out_col !== want.out_col ||
                rsp_payload.result_value !== want.result_value ||
                rsp_payload.last !== want.last) begin
               if (mismatch_count < 10)
                  $display("mismatch: exp r%0d c%0d %h l%b, got r%0d c%0d %h l%b",
                           want.out_row, want.out_col, want.result_value, want.last,
                           rsp_payload.out_row, rsp_payload.out_col,
                           rsp_payload.result_value, rsp_payload.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset sizes are zero, so this compute is empty
      push_item(OP_COMPUTE, 0, 0, '0);
      push_item(OP_UNUSED, 7, 7, 32'hffffffff);

      set_config(1'b0, 1'b0, 4'd2, 4'd2, 32'h00010000);
      push_item(OP_LOAD_H, 0, 0, 32'h7fffffff);
      push_item(OP_LOAD_H, 0, 1, 32'h80000000);
      push_item(OP_LOAD_H, 1, 0, 32'h00010000);
      push_item(OP_LOAD_H, 1, 1, 32'hffff0000);
      push_item(OP_LOAD_A, 0, 0, 32'h7fffffff);
      push_item(OP_LOAD_A, 1, 0, 32'h7fffffff);
      push_item(OP_LOAD_A, 0, 1, 32'h80000000);
      push_item(OP_LOAD_A, 1, 1, 32'h00000000);
      // H entry below the subdiagonal, never part of a product, and an A entry outside this 2x2 product
      push_item(OP_LOAD_H, 7, 0, 32'h7fffffff);
      push_item(OP_LOAD_A, 7, 7, 32'h80000000);
      push_compute();

      set_config(1'b0, 1'b1, 4'd2, 4'd2, 32'h80000000);
      push_compute();
      set_config(1'b1, 1'b0, 4'd2, 4'd2, 32'h7fffffff);
      push_compute();
      set_config(1'b1, 1'b1, 4'd2, 4'd3, 32'hffff0000);
      push_compute();
      set_config(1'b0, 1'b0, 4'd3, 4'd1, 32'h00010000);
      push_item(OP_LOAD_H, 2, 0, 32'h7fffffff);
      push_compute();
      set_config(1'b1, 1'b1, 4'd0, 4'd3, 32'h00010000);
      push_compute();

      phase = 0;
      while (request_count < ITEM_TARGET) begin
         case (phase)
            0: set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 4'd8, 4'd8,
                          pick_scale());
            1: set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 4'd15, 4'd9,
                          pick_scale());
            default: set_config(1'($urandom_range(1)), 1'($urandom_range(1)), pick_dim(),
                                pick_dim(), pick_scale());
         endcase
         seg_count = $urandom_range(1, 3);
         for (int s = 0; s < seg_count; s++) begin
            // let every outstanding result drain before sending more requests
            if (phase == 2 && s == 1) wait_idle();
            repeat ($urandom_range(0, 6))
               push_item($urandom_range(1) ? OP_LOAD_A : OP_LOAD_H, $urandom_range(7),
                         $urandom_range(7), rand_value());
            if ($urandom_range(9) == 0)
               push_item(OP_UNUSED, $urandom_range(7), $urandom_range(7), $urandom());
            if ($urandom_range(7) != 0) push_compute();
         end
         phase++;
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
